// ===== design/scsa_pkg.sv =====
// shared constants for the size class slab allocator
package scsa_pkg;
	localparam int NumClasses = 8;
	localparam int ArenaBytes = 4096;
	localparam int MaxArenas = 16;
	localparam int GranuleBytes = 16;

	localparam int AddrW = 16;
	localparam int CntW = 17;
	localparam int ReqW = 48;
	localparam int SizeW = 24;
	localparam int CsW = 13;
	localparam int NumRegs = 8;
	localparam int PaddrW = 5;

	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_FREE = 2'd1;
	localparam logic [1:0] REQ_RESET = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_TOO_LARGE = 2'd1;
	localparam logic [1:0] ST_OOM = 2'd2;

	localparam logic [CntW-1:0] CNT_MAX = '1;
	localparam logic [ReqW-1:0] REQ_MAX = '1;

	localparam logic [CsW-1:0] CLASS_RESET [NumRegs] = '{
		13'd16, 13'd32, 13'd64, 13'd128, 13'd256, 13'd512, 13'd1024, 13'd2048
	};
endpackage

// ===== design/scsa_ram.sv =====
// generic single-port-write ram with registered read
module scsa_ram #(
	parameter int Width = 16,
	parameter int Depth = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== design/size_class_slab_allocator_top.sv =====
// top level of the size class slab allocator
// a result passes through the result register and then the output register; a list pop first
// waits in S_POP for the link read, an arena map in S_DIV (remainder search) and then S_MAP
// throughput: one request a cycle while results are taken; in_ready is low during a pop or map
// a waiting result sits in the output register while the next request runs
// reset: arst_n clears lists, cursors, counters and restores class sizes;
// link memory needs no clearing, since each link is written before it is read
module size_class_slab_allocator_top #(
	parameter int NumClasses = scsa_pkg::NumClasses,
	parameter int ArenaBytes = scsa_pkg::ArenaBytes,
	parameter int MaxArenas = scsa_pkg::MaxArenas,
	parameter int GranuleBytes = scsa_pkg::GranuleBytes
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [scsa_pkg::PaddrW-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    req_type,
	input  logic [scsa_pkg::SizeW-1:0]    req_size,
	input  logic [scsa_pkg::AddrW-1:0]    free_addr,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [scsa_pkg::AddrW-1:0]    slab_addr,
	output logic [1:0]                    status,
	output logic [3:0]                    class_index,
	output logic [scsa_pkg::ReqW-1:0]     total_requested,
	output logic [scsa_pkg::CntW-1:0]     live_bytes,
	output logic [scsa_pkg::CntW-1:0]     free_listed_bytes,
	output logic [4:0]                    arenas_mapped
);
	localparam int AW = scsa_pkg::AddrW;
	localparam int CW = scsa_pkg::CntW;
	localparam int LinkDepth = 65536 / GranuleBytes;
	localparam int LinkAw = $clog2(LinkDepth);
	localparam int GShift = $clog2(GranuleBytes);
	localparam int AShift = $clog2(ArenaBytes);
	localparam int Fit = 65536 / ArenaBytes;
	localparam int PoolLimit = (MaxArenas < Fit) ? MaxArenas : Fit;
	localparam int ClsW = (NumClasses > 1) ? $clog2(NumClasses) : 1;
	// remainder search: one quotient bit per cycle
	localparam int QW = AShift - GShift + 1;
	localparam int DW = AShift + QW;
	localparam int SW = (QW > 1) ? $clog2(QW) : 1;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_POP = 2'd1;
	localparam logic [1:0] S_DIV = 2'd2;
	localparam logic [1:0] S_MAP = 2'd3;

	// configuration
	logic [scsa_pkg::CsW-1:0] class_size_q [scsa_pkg::NumRegs];
	logic [2:0] reg_idx;
	assign reg_idx = paddr[4:2];
	assign pready = 1'b1;
	assign prdata = {19'd0, class_size_q[reg_idx]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < scsa_pkg::NumRegs; i++) begin
				class_size_q[i] <= scsa_pkg::CLASS_RESET[i];
			end
		end else if (psel && penable && pwrite) begin
			class_size_q[reg_idx] <= pwdata[scsa_pkg::CsW-1:0];
		end
	end

	// effective slab sizes (rounded up to a granule, zero as one granule)
	logic [13:0] slab_sz [NumClasses];
	always_comb begin
		for (int i = 0; i < NumClasses; i++) begin
			logic [13:0] v;
			v = {1'b0, class_size_q[i]};
			if (v == '0) begin
				v = 14'(GranuleBytes);
			end
			v = v + 14'(GranuleBytes - 1);
			slab_sz[i] = {v[13:GShift], {GShift{1'b0}}};
		end
	end

	// state
	logic [1:0] state_q, state_d;
	logic [AW:0] head_q [NumClasses];
	logic [AW:0] head_d [NumClasses];
	logic [AW:0] cursor_q [NumClasses];
	logic [AW:0] cursor_d [NumClasses];
	logic [4:0] arena_q, arena_d;
	logic [scsa_pkg::ReqW-1:0] req_tot_q, req_tot_d;
	logic [CW-1:0] live_q, live_d, free_q, free_d;

	// request held while a pop or an arena map is in progress
	logic [ClsW-1:0] op_cls_q, op_cls_d;
	logic [13:0] op_s_q, op_s_d;
	logic [DW-1:0] rem_q, rem_d, dsr_q, dsr_d;
	logic [SW-1:0] step_q, step_d;

	// finished result, counters are the live state
	logic done_q, done_d;
	logic [AW-1:0] r_addr_q, r_addr_d;
	logic [1:0] r_status_q, r_status_d;
	logic [3:0] r_cls_q, r_cls_d;

	// output register
	logic out_valid_q;
	logic [AW-1:0] o_addr_q;
	logic [1:0] o_status_q;
	logic [3:0] o_cls_q;
	logic [scsa_pkg::ReqW-1:0] o_req_q;
	logic [CW-1:0] o_live_q, o_free_q;
	logic [4:0] o_arena_q;

	logic move;
	assign move = done_q && (!out_valid_q || out_ready);
	assign in_ready = (state_q == S_IDLE) && (!done_q || move);
	logic acc;
	assign acc = in_valid && in_ready;

	// class match
	logic [3:0] pick;
	logic fits;
	always_comb begin
		pick = 4'(NumClasses);
		for (int i = NumClasses - 1; i >= 0; i--) begin
			if (req_size <= {10'd0, slab_sz[i]}) begin
				pick = 4'(i);
			end
		end
		fits = (pick < 4'(NumClasses));
	end
	logic [ClsW-1:0] c;
	assign c = pick[ClsW-1:0];
	logic [13:0] s;
	assign s = slab_sz[c];

	// link memory
	logic link_we;
	logic [LinkAw-1:0] link_waddr, link_raddr;
	logic [AW:0] link_wdata, link_rdata;

	scsa_ram #(.Width(AW + 1), .Depth(LinkDepth)) u_link (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	assign link_waddr = free_addr[AW-1:GShift];
	assign link_wdata = head_q[c];
	assign link_we = acc && req_type == scsa_pkg::REQ_FREE && fits;
	assign link_raddr = head_q[c][AW-1:GShift];

	function automatic logic [CW-1:0] sat_add(logic [CW-1:0] a, logic [CW:0] b);
		logic [CW+1:0] t;
		t = {2'b0, a} + {1'b0, b};
		return (t > {2'b0, scsa_pkg::CNT_MAX}) ? scsa_pkg::CNT_MAX : t[CW-1:0];
	endfunction

	function automatic logic [CW-1:0] sat_sub(logic [CW-1:0] a, logic [CW:0] b);
		return ({1'b0, a} > b) ? CW'({1'b0, a} - b) : '0;
	endfunction

	logic [scsa_pkg::ReqW:0] tsum;
	assign tsum = {1'b0, req_tot_q} + (scsa_pkg::ReqW + 1)'(req_size);

	// list and cursor operands of the request at the input
	logic [AW-1:0] cur_addr;
	logic [AW-1:0] cur_off;
	assign cur_addr = cursor_q[c][AW-1:0];
	assign cur_off = cur_addr & AW'(ArenaBytes - 1);

	// arena map after the remainder search: carved bytes = arena - remainder
	logic [AW+1:0] carve_bytes;
	logic [AW+1:0] base;
	logic [AW+1:0] top_off;
	logic [AW+1:0] top_addr;
	always_comb begin
		carve_bytes = (AW + 2)'(ArenaBytes) - (AW + 2)'(rem_q);
		base = (AW + 2)'(32'(arena_q) << AShift);
		top_off = carve_bytes - (AW + 2)'(op_s_q);
		top_addr = base + top_off;
	end

	always_comb begin
		state_d = state_q;
		head_d = head_q;
		cursor_d = cursor_q;
		arena_d = arena_q;
		req_tot_d = req_tot_q;
		live_d = live_q;
		free_d = free_q;
		op_cls_d = op_cls_q;
		op_s_d = op_s_q;
		rem_d = rem_q;
		dsr_d = dsr_q;
		step_d = step_q;
		done_d = done_q && !move;
		r_addr_d = r_addr_q;
		r_status_d = r_status_q;
		r_cls_d = r_cls_q;
		case (state_q)
			S_POP: begin
				// link data is back: finish the pop
				head_d[op_cls_q] = link_rdata;
				done_d = 1'b1;
				state_d = S_IDLE;
			end
			S_DIV: begin
				if (rem_q >= dsr_q) begin
					rem_d = rem_q - dsr_q;
				end
				dsr_d = dsr_q >> 1;
				step_d = step_q - SW'(1);
				if (step_q == '0) begin
					state_d = S_MAP;
				end
			end
			S_MAP: begin
				r_addr_d = top_addr[AW-1:0];
				free_d = sat_sub(sat_add(free_q, (CW + 1)'(carve_bytes)), {4'b0, op_s_q});
				live_d = sat_add(live_q, {4'b0, op_s_q});
				arena_d = arena_q + 5'd1;
				// more than one slab in the arena leaves a cursor below the top one
				if (top_off >= (AW + 2)'(op_s_q)) begin
					cursor_d[op_cls_q] = {1'b1, top_addr[AW-1:0] - AW'(op_s_q)};
				end else begin
					cursor_d[op_cls_q] = '0;
				end
				done_d = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				if (acc) begin
					r_addr_d = '0;
					r_status_d = scsa_pkg::ST_OK;
					r_cls_d = '0;
					done_d = 1'b1;
					case (req_type)
						scsa_pkg::REQ_ALLOC: begin
							req_tot_d = tsum[scsa_pkg::ReqW] ? scsa_pkg::REQ_MAX :
								tsum[scsa_pkg::ReqW-1:0];
							r_cls_d = pick;
							if (!fits) begin
								r_status_d = scsa_pkg::ST_TOO_LARGE;
							end else if (head_q[c][AW]) begin
								r_addr_d = head_q[c][AW-1:0];
								op_cls_d = c;
								state_d = S_POP;
								done_d = 1'b0;
								free_d = sat_sub(free_q, {4'b0, s});
								live_d = sat_add(live_q, {4'b0, s});
							end else if (cursor_q[c][AW]) begin
								r_addr_d = cur_addr;
								if ({2'b0, cur_off} >= {4'b0, s}) begin
									cursor_d[c] = {1'b1, cur_addr - AW'(s)};
								end else begin
									cursor_d[c] = '0;
								end
								free_d = sat_sub(free_q, {4'b0, s});
								live_d = sat_add(live_q, {4'b0, s});
							end else if (32'(s) > 32'(ArenaBytes) ||
									32'(arena_q) >= 32'(PoolLimit)) begin
								r_status_d = scsa_pkg::ST_OOM;
							end else begin
								op_cls_d = c;
								op_s_d = s;
								rem_d = DW'(ArenaBytes);
								dsr_d = DW'(s) << (QW - 1);
								step_d = SW'(QW - 1);
								state_d = S_DIV;
								done_d = 1'b0;
							end
						end
						scsa_pkg::REQ_FREE: begin
							r_cls_d = pick;
							if (!fits) begin
								r_status_d = scsa_pkg::ST_TOO_LARGE;
							end else begin
								head_d[c] = {1'b1, free_addr};
								live_d = sat_sub(live_q, {4'b0, s});
								free_d = sat_add(free_q, {4'b0, s});
							end
						end
						scsa_pkg::REQ_RESET: begin
							for (int i = 0; i < NumClasses; i++) begin
								head_d[i] = '0;
								cursor_d[i] = '0;
							end
							arena_d = '0;
							req_tot_d = '0;
							live_d = '0;
							free_d = '0;
						end
						default: begin
						end
					endcase
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int i = 0; i < NumClasses; i++) begin
				head_q[i] <= '0;
				cursor_q[i] <= '0;
			end
			arena_q <= '0;
			req_tot_q <= '0;
			live_q <= '0;
			free_q <= '0;
			op_cls_q <= '0;
			op_s_q <= '0;
			rem_q <= '0;
			dsr_q <= '0;
			step_q <= '0;
			done_q <= 1'b0;
			r_addr_q <= '0;
			r_status_q <= scsa_pkg::ST_OK;
			r_cls_q <= '0;
		end else begin
			state_q <= state_d;
			head_q <= head_d;
			cursor_q <= cursor_d;
			arena_q <= arena_d;
			req_tot_q <= req_tot_d;
			live_q <= live_d;
			free_q <= free_d;
			op_cls_q <= op_cls_d;
			op_s_q <= op_s_d;
			rem_q <= rem_d;
			dsr_q <= dsr_d;
			step_q <= step_d;
			done_q <= done_d;
			r_addr_q <= r_addr_d;
			r_status_q <= r_status_d;
			r_cls_q <= r_cls_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			o_addr_q <= '0;
			o_status_q <= scsa_pkg::ST_OK;
			o_cls_q <= '0;
			o_req_q <= '0;
			o_live_q <= '0;
			o_free_q <= '0;
			o_arena_q <= '0;
		end else if (move) begin
			out_valid_q <= 1'b1;
			o_addr_q <= r_addr_q;
			o_status_q <= r_status_q;
			o_cls_q <= r_cls_q;
			o_req_q <= req_tot_q;
			o_live_q <= live_q;
			o_free_q <= free_q;
			o_arena_q <= arena_q;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign slab_addr = o_addr_q;
	assign status = o_status_q;
	assign class_index = o_cls_q;
	assign total_requested = o_req_q;
	assign live_bytes = o_live_q;
	assign free_listed_bytes = o_free_q;
	assign arenas_mapped = o_arena_q;
endmodule

// ===== dv/tb.sv =====
// self-checking testbench for the size class slab allocator
module tb;
	localparam int SizeW = scsa_pkg::SizeW;
	localparam int AddrW = scsa_pkg::AddrW;
	localparam int ReqW = scsa_pkg::ReqW;
	localparam int CntW = scsa_pkg::CntW;
	localparam int CsW = scsa_pkg::CsW;
	localparam int PaddrW = scsa_pkg::PaddrW;
	localparam int NumRegs = scsa_pkg::NumRegs;
	localparam int NumClasses = scsa_pkg::NumClasses;
	localparam int ArenaBytes = scsa_pkg::ArenaBytes;
	localparam int MaxArenas = scsa_pkg::MaxArenas;
	localparam int GranuleBytes = scsa_pkg::GranuleBytes;

	typedef struct packed {
		logic [1:0]       kind;
		logic [SizeW-1:0] size;
		logic [AddrW-1:0] addr;
	} alloc_req_t;

	typedef struct packed {
		logic [AddrW-1:0] addr;
		logic [1:0]       st;
		logic [3:0]       cls;
		logic [ReqW-1:0]  requested;
		logic [CntW-1:0]  live;
		logic [CntW-1:0]  free_bytes;
		logic [4:0]       arenas;
	} alloc_resp_t;

	typedef struct packed {
		logic [AddrW-1:0] addr;
		logic [SizeW-1:0] size;
	} held_slab_t;

	localparam logic [1:0] REQ_NOP = 2'd3;
	localparam int LinkDepth = 65536 / GranuleBytes;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [PaddrW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 0, in_ready, out_valid, out_ready = 0;
	logic [1:0] req_type = '0;
	logic [SizeW-1:0] req_size = '0;
	logic [AddrW-1:0] free_addr = '0;
	logic [AddrW-1:0] slab_addr;
	logic [1:0] status;
	logic [3:0] class_index;
	logic [ReqW-1:0] total_requested;
	logic [CntW-1:0] live_bytes, free_listed_bytes;
	logic [4:0] arenas_mapped;

	size_class_slab_allocator_top dut (.*);

	// shadow allocator state
	logic [CsW-1:0] class_cfg [NumRegs];
	logic [16:0] head_q [8];
	logic [16:0] link_mem [LinkDepth];
	logic [16:0] cursor_q [8];
	int unsigned arena_cnt, live_cnt, free_cnt;
	logic [ReqW-1:0] req_sum;

	alloc_req_t pending_reqs[$];
	alloc_resp_t expected_resps[$];
	held_slab_t held_slabs[$];
	int send_idle = 15, recv_idle = 77;
	int errors = 0, checked = 0, n_oom = 0, n_big = 0;

	initial forever #4 clk = ~clk;

	function automatic int unsigned class_bytes(int c);
		int unsigned v;
		v = class_cfg[c];
		if (v == 0) v = GranuleBytes;
		return ((v + GranuleBytes - 1) / GranuleBytes) * GranuleBytes;
	endfunction

	function automatic int unsigned find_class(int unsigned sz);
		for (int i = 0; i < NumClasses; i++)
			if (sz <= class_bytes(i)) return i;
		return NumClasses;
	endfunction

	function automatic int unsigned sat_cnt(longint v);
		if (v < 0) return 0;
		if (v > scsa_pkg::CNT_MAX) return 32'(scsa_pkg::CNT_MAX);
		return 32'(v);
	endfunction

	function automatic void clear_shadow();
		for (int i = 0; i < 8; i++) begin
			head_q[i] = '0;
			cursor_q[i] = '0;
		end
		arena_cnt = 0;
		live_cnt = 0;
		free_cnt = 0;
		req_sum = '0;
	endfunction

	function automatic alloc_resp_t serve_request(alloc_req_t r);
		alloc_resp_t o;
		int unsigned c, s, a, base, cnt, lim;
		logic [ReqW:0] sum;
		o = '0;
		a = 0;
		if (r.kind == scsa_pkg::REQ_ALLOC) begin
			sum = {1'b0, req_sum} + (ReqW + 1)'(r.size);
			req_sum = sum[ReqW] ? scsa_pkg::REQ_MAX : sum[ReqW-1:0];
			c = find_class(r.size);
			o.cls = 4'(c);
			if (c >= NumClasses) begin
				o.st = scsa_pkg::ST_TOO_LARGE;
			end else begin
				s = class_bytes(c);
				lim = (65536 / ArenaBytes < MaxArenas) ? 65536 / ArenaBytes : MaxArenas;
				if (head_q[c][16]) begin
					a = 32'(head_q[c][15:0]);
					head_q[c] = link_mem[a / GranuleBytes];
				end else if (cursor_q[c][16]) begin
					a = 32'(cursor_q[c][15:0]);
					cursor_q[c] = (a % ArenaBytes >= s) ? {1'b1, 16'(a - s)} : '0;
				end else if (s > ArenaBytes || arena_cnt >= lim) begin
					o.st = scsa_pkg::ST_OOM;
				end else begin
					base = arena_cnt * ArenaBytes;
					cnt = ArenaBytes / s;
					a = base + (cnt - 1) * s;
					free_cnt = sat_cnt(longint'(free_cnt) + cnt * s);
					arena_cnt++;
					cursor_q[c] = cnt > 1 ? {1'b1, 16'(a - s)} : '0;
				end
				if (o.st == scsa_pkg::ST_OK) begin
					free_cnt = sat_cnt(longint'(free_cnt) - s);
					live_cnt = sat_cnt(longint'(live_cnt) + s);
				end else begin
					a = 0;
				end
			end
		end else if (r.kind == scsa_pkg::REQ_FREE) begin
			c = find_class(r.size);
			o.cls = 4'(c);
			if (c >= NumClasses) begin
				o.st = scsa_pkg::ST_TOO_LARGE;
			end else begin
				s = class_bytes(c);
				link_mem[r.addr / GranuleBytes] = head_q[c];
				head_q[c] = {1'b1, r.addr};
				live_cnt = sat_cnt(longint'(live_cnt) - s);
				free_cnt = sat_cnt(longint'(free_cnt) + s);
			end
		end else if (r.kind == scsa_pkg::REQ_RESET) begin
			clear_shadow();
		end
		o.addr = 16'(a);
		o.requested = req_sum;
		o.live = 17'(live_cnt);
		o.free_bytes = 17'(free_cnt);
		o.arenas = 5'(arena_cnt);
		return o;
	endfunction

	// predict at generation time; requests are accepted in the same order
	task automatic queue_req(logic [1:0] k, logic [SizeW-1:0] sz, logic [AddrW-1:0] fa);
		alloc_req_t r;
		alloc_resp_t o;
		r = '{kind: k, size: sz, addr: fa};
		o = serve_request(r);
		pending_reqs.insert(pending_reqs.size(), r);
		expected_resps.insert(expected_resps.size(), o);
		if (o.st == scsa_pkg::ST_OOM) n_oom++;
		if (o.st == scsa_pkg::ST_TOO_LARGE) n_big++;
		if (k == scsa_pkg::REQ_ALLOC && o.st == scsa_pkg::ST_OK)
			held_slabs.insert(held_slabs.size(), held_slab_t'{addr: o.addr, size: sz});
		if (k == scsa_pkg::REQ_RESET) held_slabs.delete();
	endtask

	task automatic write_reg(int idx, logic [CsW-1:0] val);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= PaddrW'(idx * 4);
		pwdata <= 32'(val);
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		class_cfg[idx] = val;
	endtask

	task automatic random_reqs(int n);
		int pick, j;
		int unsigned top;
		held_slab_t h;
		top = class_bytes(NumClasses - 1);
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 48) begin
				queue_req(scsa_pkg::REQ_ALLOC, SizeW'($urandom_range(top)), 16'($urandom));
			end else if (pick < 83 && held_slabs.size() > 0) begin
				j = $urandom_range(held_slabs.size() - 1);
				h = held_slabs[j];
				held_slabs.delete(j);
				queue_req(scsa_pkg::REQ_FREE, h.size, h.addr);
			end else if (pick < 88) begin
				queue_req(scsa_pkg::REQ_FREE, SizeW'($urandom_range(top)), 16'($urandom));
			end else if (pick < 91) begin
				queue_req(scsa_pkg::REQ_RESET, SizeW'($urandom), 16'($urandom));
			end else if (pick < 93) begin
				queue_req(REQ_NOP, SizeW'($urandom), 16'($urandom));
			end else begin
				queue_req($urandom_range(1) ? scsa_pkg::REQ_ALLOC : scsa_pkg::REQ_FREE,
					SizeW'($urandom), 16'($urandom));
			end
		end
	endtask

	task automatic drain();
		while (pending_reqs.size() > 0 || in_valid || expected_resps.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// driver
	always @(posedge clk) begin
		if (!in_valid || in_ready) begin
			if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
				alloc_req_t r;
				r = pending_reqs.pop_front();
				in_valid <= 1;
				req_type <= r.kind;
				req_size <= r.size;
				free_addr <= r.addr;
			end else begin
				in_valid <= 0;
			end
		end
	end

	always @(posedge clk) out_ready <= arst_n && ($urandom_range(99) >= recv_idle);

	// monitor
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (expected_resps.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				alloc_resp_t e;
				e = expected_resps.pop_front();
				checked++;
				if (slab_addr !== e.addr) begin
					$error("slab_addr exp %0h got %0h", e.addr, slab_addr); errors++;
				end
				if (status !== e.st) begin
					$error("status exp %0d got %0d", e.st, status); errors++;
				end
				if (class_index !== e.cls) begin
					$error("class_index exp %0d got %0d", e.cls, class_index); errors++;
				end
				if (total_requested !== e.requested) begin
					$error("total_requested exp %0d got %0d", e.requested, total_requested);
					errors++;
				end
				if (live_bytes !== e.live) begin
					$error("live_bytes exp %0d got %0d", e.live, live_bytes); errors++;
				end
				if (free_listed_bytes !== e.free_bytes) begin
					$error("free_listed_bytes exp %0d got %0d", e.free_bytes,
						free_listed_bytes);
					errors++;
				end
				if (arenas_mapped !== e.arenas) begin
					$error("arenas_mapped exp %0d got %0d", e.arenas, arenas_mapped);
					errors++;
				end
			end
		end
	end

	initial begin
		#4_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		logic [CsW-1:0] vals [NumRegs];
		for (int i = 0; i < NumRegs; i++) class_cfg[i] = scsa_pkg::CLASS_RESET[i];
		clear_shadow();
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: default classes
		queue_req(scsa_pkg::REQ_ALLOC, 24'd0, 16'h0);
		queue_req(scsa_pkg::REQ_ALLOC, 24'd16, 16'h0);
		queue_req(scsa_pkg::REQ_ALLOC, 24'd17, 16'h0);
		queue_req(scsa_pkg::REQ_ALLOC, 24'd2048, 16'h0);
		queue_req(scsa_pkg::REQ_ALLOC, 24'd2048, 16'h0);
		queue_req(scsa_pkg::REQ_ALLOC, 24'd2048, 16'h0);
		queue_req(scsa_pkg::REQ_ALLOC, 24'd2049, 16'h0);
		queue_req(scsa_pkg::REQ_ALLOC, 24'hFFFFFF, 16'hFFFF);
		queue_req(scsa_pkg::REQ_FREE, 24'd16, expected_resps[1].addr);
		queue_req(scsa_pkg::REQ_ALLOC, 24'd1, 16'h0);
		queue_req(scsa_pkg::REQ_FREE, 24'd32, expected_resps[2].addr);
		queue_req(scsa_pkg::REQ_FREE, 24'd32, expected_resps[2].addr);
		queue_req(scsa_pkg::REQ_ALLOC, 24'd20, 16'h0);
		queue_req(scsa_pkg::REQ_ALLOC, 24'd20, 16'h0);
		queue_req(scsa_pkg::REQ_FREE, 24'd1, 16'hFFFF);
		queue_req(scsa_pkg::REQ_FREE, 24'hFFFFFF, 16'h1234);
		queue_req(REQ_NOP, 24'hFFFFFF, 16'hFFFF);
		queue_req(scsa_pkg::REQ_RESET, 24'd0, 16'h0);
		queue_req(scsa_pkg::REQ_ALLOC, 24'd100, 16'h0);
		held_slabs.delete();
		random_reqs(450);
		drain();

		// largest classes: every allocate maps an arena until the pool runs out
		send_idle = 77;
		recv_idle = 15;
		for (int i = 0; i < NumRegs; i++) write_reg(i, 13'd4096);
		queue_req(scsa_pkg::REQ_RESET, 24'd0, 16'h0);
		for (int i = 0; i < 18; i++) queue_req(scsa_pkg::REQ_ALLOC, 24'd4096, 16'h0);
		random_reqs(400);
		drain();

		// smallest and unaligned classes, back to back
		send_idle = 0;
		recv_idle = 0;
		write_reg(0, 13'd16);
		for (int i = 1; i < NumRegs; i++) write_reg(i, 13'($urandom_range(1, 4096)));
		random_reqs(500);
		drain();

		// random ascending classes, one zero-sized class register
		vals[0] = 13'd0;
		for (int i = 1; i < NumRegs; i++)
			vals[i] = vals[i-1] + 13'($urandom_range(1, 512 / NumRegs) * GranuleBytes);
		for (int i = 0; i < NumRegs; i++) write_reg(i, vals[i]);
		random_reqs(580);
		drain();

		$display("checked %0d results (%0d too_large, %0d out_of_memory)", checked,
			n_big, n_oom);
		$display("covered four class settings, pool exhaustion, double and stray frees");
		if (errors == 0 && expected_resps.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
